>>> rtl/mmdds_pkg.sv
// Shared types, constants and sine table for the multitone DDS.
`timescale 1ns / 1ps
`default_nettype none

package mmdds_pkg;

  localparam int MODE_W        = 2;
  localparam int CSEL_W        = 3;
  localparam int TSEL_W        = 2;
  localparam int FREQ_W        = 16;
  localparam int AMP_W         = 14;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 14;
  localparam int MASK_W        = 5;
  localparam int OUT_CHANNELS  = 5;
  localparam int OUT_W         = 16;
  localparam int PHASE_W       = 32;
  localparam int MAG_W         = 15;
  localparam int PROD_W        = AMP_W + MAG_W;
  localparam int QUOT_W        = 15;
  localparam int SUM_W         = 18;

  localparam int TONE_SPACING  = 20;
  localparam int DIV_CONST     = 32767;
  localparam int SAT_MAX       = 32767;
  localparam int SAT_MIN       = -32768;

  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREQ    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GEN_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MASK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_AMPLITUDE = 2'd2;

  localparam logic [MASK_W-1:0] MASK_RESET = 5'd1;
  localparam logic [AMP_W-1:0]  AMP_RESET  = 14'd3000;

  localparam int BASE_FREQ [OUT_CHANNELS] = '{980, 940, 980, 1020, 1060};

  localparam logic [MAG_W-1:0] QUARTER_SINE [64] = '{
    15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,  15'd5602,
    15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278, 15'd11039, 15'd11793,
    15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446, 15'd16151, 15'd16846, 15'd17530,
    15'd18204, 15'd18868, 15'd19519, 15'd20159, 15'd20787, 15'd21403, 15'd22005, 15'd22594,
    15'd23170, 15'd23731, 15'd24279, 15'd24811, 15'd25329, 15'd25831, 15'd26318, 15'd26789,
    15'd27244, 15'd27683, 15'd28105, 15'd28510, 15'd28898, 15'd29269, 15'd29622, 15'd29957,
    15'd30274, 15'd30572, 15'd30852, 15'd31113, 15'd31356, 15'd31579, 15'd31783, 15'd31968,
    15'd32133, 15'd32279, 15'd32405, 15'd32512, 15'd32598, 15'd32665, 15'd32713, 15'd32740
  };

  // Magnitude of the sine for a phase; the sign is the top phase bit.
  function automatic logic [MAG_W-1:0] sine_mag(input logic [PHASE_W-1:0] ph);
    logic [5:0] k;
    k = ph[29:24];
    if (ph[30]) begin
      k = ~k;
    end
    return QUARTER_SINE[k];
  endfunction

endpackage

`default_nettype wire

>>> rtl/mmdds_div.sv
// Reciprocal-multiply unit that turns a frequency into a 32-bit phase step.
`timescale 1ns / 1ps
`default_nettype none

module mmdds_div #(
  parameter int DIVISOR = 10000
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [mmdds_pkg::FREQ_W-1:0] hz,
  output logic                             done,
  output logic [mmdds_pkg::PHASE_W-1:0]    quot
);
  import mmdds_pkg::*;

  localparam int DIGIT_W = FREQ_W;
  localparam int RECIP_W = 4 * DIGIT_W;
  localparam int STEPS   = RECIP_W / DIGIT_W;
  localparam int CNT_W   = $clog2(STEPS);
  localparam int DW      = $clog2(DIVISOR);
  localparam int SHIFT   = FREQ_W + DW;
  localparam int ACC_W   = FREQ_W + RECIP_W;
  localparam logic [127:0] RECIP_FULL =
    ((128'd1 << (FREQ_W + PHASE_W + DW)) + 128'(DIVISOR) - 128'd1) / 128'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic [ACC_W-1:0]     acc;
  logic [RECIP_W-1:0]   recip_sh;
  logic [FREQ_W-1:0]    hz_q;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic [2*DIGIT_W-1:0] part;

  // Multiply by the scaled reciprocal one 16-bit digit at a time, top digit first.
  assign part = hz_q * recip_sh[RECIP_W-1 -: DIGIT_W];
  assign quot = acc[SHIFT +: PHASE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        acc      <= '0;
        recip_sh <= RECIP;
        hz_q     <= hz;
      end else if (busy) begin
        acc      <= {acc[ACC_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + ACC_W'(part);
        recip_sh <= recip_sh << DIGIT_W;
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/multichannel_multitone_dds.sv
// Top level: five-output, multitone DDS with one shared tone datapath.
// Tick: each enabled channel passes S_ADV, S_MUL and S_ACC per tone, then S_SAT; a disabled
//   channel passes S_ADV only; S_DONE loads the output register, waiting while it is full, and
//   input is ready again after it. Restart and ignored transactions stay in S_IDLE.
// Frequency write: S_DIV waits for the 4-step reciprocal multiply.
// Reset: phases cleared, steps set to their default frequencies, registers to defaults,
//   output empty; ready in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_multitone_dds #(
  parameter int NUM_CHANNELS = 5,
  parameter int NUM_TONES    = 3,
  parameter int SAMPLE_RATE  = 10000
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [mmdds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mmdds_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [mmdds_pkg::MODE_W-1:0]     mode,
  input  wire logic [mmdds_pkg::CSEL_W-1:0]     channel_sel,
  input  wire logic [mmdds_pkg::TSEL_W-1:0]     tone_sel,
  input  wire logic [mmdds_pkg::FREQ_W-1:0]     freq_hz,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [mmdds_pkg::OUT_W-1:0]    chan0_out,
  output logic signed [mmdds_pkg::OUT_W-1:0]    chan1_out,
  output logic signed [mmdds_pkg::OUT_W-1:0]    chan2_out,
  output logic signed [mmdds_pkg::OUT_W-1:0]    chan3_out,
  output logic signed [mmdds_pkg::OUT_W-1:0]    chan4_out
);
  import mmdds_pkg::*;

  localparam int TW = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_ADV, S_MUL, S_ACC, S_SAT, S_DONE
  } state_t;

  state_t state;

  logic                  gen_enable;
  logic [MASK_W-1:0]     channel_mask;
  logic [AMP_W-1:0]      tone_amplitude;

  logic [PHASE_W-1:0]    phase_acc  [NUM_CHANNELS][NUM_TONES];
  logic [PHASE_W-1:0]    phase_step [NUM_CHANNELS][NUM_TONES];

  logic [CSEL_W-1:0]     chan_idx;
  logic [TW-1:0]         tone_idx;
  logic [CSEL_W-1:0]     wchan;
  logic [TSEL_W-1:0]     wtone;
  logic [MAG_W-1:0]      mag;
  logic                  neg;
  logic [PROD_W-1:0]     prod;
  logic signed [SUM_W-1:0] sum;
  logic signed [OUT_W-1:0] res [OUT_CHANNELS];

  logic                  in_fire;
  logic                  freq_ok;
  logic                  div_start;
  logic                  div_done;
  logic [PHASE_W-1:0]    div_quot;
  logic                  clear_all;
  logic                  chan_act;
  logic                  acc_we;
  logic [PHASE_W-1:0]    phase_sel;
  logic [PHASE_W-1:0]    step_sel;
  logic [PHASE_W-1:0]    phase_new;
  logic [PROD_W-MAG_W-1:0] q0;
  logic [OUT_W-1:0]      rem_est;
  logic [QUOT_W-1:0]     quo;
  logic signed [SUM_W-1:0] tone_val;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [OUT_W-1:0] sat_val;
  logic                  tone_last;
  logic                  chan_last;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign freq_ok   = (freq_hz != '0) && (int'(channel_sel) < NUM_CHANNELS)
                     && (int'(tone_sel) < NUM_TONES);
  assign div_start = in_fire && (mode == MODE_FREQ) && freq_ok;
  assign clear_all = in_fire && (mode == MODE_RESTART);
  assign chan_act  = (int'(chan_idx) < NUM_CHANNELS) && channel_mask[chan_idx];
  assign acc_we    = (state == S_ADV) && chan_act;
  assign tone_last = (tone_idx == TW'(NUM_TONES - 1));
  assign chan_last = (chan_idx == CSEL_W'(OUT_CHANNELS - 1));

  mmdds_div #(
    .DIVISOR (SAMPLE_RATE)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .hz    (freq_hz),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    phase_sel = '0;
    step_sel  = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      for (int t = 0; t < NUM_TONES; t++) begin
        if (chan_idx == CSEL_W'(c) && tone_idx == TW'(t)) begin
          phase_sel = phase_acc[c][t];
          step_sel  = phase_step[c][t];
        end
      end
    end
    phase_new = phase_sel + step_sel;
  end

  // Divide by 32767: estimate with a shift, correct once.
  always_comb begin
    q0       = prod[PROD_W-1:MAG_W];
    rem_est  = {1'b0, prod[MAG_W-1:0]} + OUT_W'(q0);
    quo      = QUOT_W'(q0) + QUOT_W'(rem_est >= OUT_W'(DIV_CONST));
    tone_val = neg ? -SUM_W'(quo) : SUM_W'(quo);
    sum_next = sum + tone_val;
    if (sum > SUM_W'(SAT_MAX)) begin
      sat_val = OUT_W'(SAT_MAX);
    end else if (sum < SUM_W'(SAT_MIN)) begin
      sat_val = OUT_W'(SAT_MIN);
    end else begin
      sat_val = sum[OUT_W-1:0];
    end
  end

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    for (genvar t = 0; t < NUM_TONES; t++) begin : g_tone
      localparam logic [PHASE_W-1:0] DEF_STEP = PHASE_W'(
        ((64'(BASE_FREQ[c]) + 64'(TONE_SPACING * t)) << PHASE_W) / 64'(SAMPLE_RATE));

      always_ff @(posedge clk) begin
        if (rst) begin
          phase_acc[c][t]  <= '0;
          phase_step[c][t] <= DEF_STEP;
        end else begin
          if (clear_all) begin
            phase_acc[c][t] <= '0;
          end else if (acc_we && chan_idx == CSEL_W'(c) && tone_idx == TW'(t)) begin
            phase_acc[c][t] <= phase_new;
          end
          if (div_done && wchan == CSEL_W'(c) && int'(wtone) == t) begin
            phase_step[c][t] <= div_quot;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      gen_enable     <= 1'b0;
      channel_mask   <= MASK_RESET;
      tone_amplitude <= AMP_RESET;
      out_valid      <= 1'b0;
      chan_idx       <= '0;
      tone_idx       <= '0;
      sum            <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GEN_ENABLE:     gen_enable     <= cfg_data[0];
          REG_CHANNEL_MASK:   channel_mask   <= cfg_data[MASK_W-1:0];
          REG_TONE_AMPLITUDE: tone_amplitude <= cfg_data[AMP_W-1:0];
          default: ;
        endcase
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (div_start) begin
              wchan <= channel_sel;
              wtone <= tone_sel;
              state <= S_DIV;
            end else if (mode == MODE_TICK && gen_enable) begin
              chan_idx <= '0;
              tone_idx <= '0;
              sum      <= '0;
              state    <= S_ADV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_IDLE;
          end
        end
        S_ADV: begin
          if (chan_act) begin
            mag   <= sine_mag(phase_new);
            neg   <= phase_new[PHASE_W-1];
            state <= S_MUL;
          end else begin
            res[chan_idx] <= '0;
            chan_idx      <= chan_idx + 1'b1;
            if (chan_last) begin
              state <= S_DONE;
            end
          end
        end
        S_MUL: begin
          prod  <= PROD_W'(tone_amplitude) * PROD_W'(mag);
          state <= S_ACC;
        end
        S_ACC: begin
          sum <= sum_next;
          if (tone_last) begin
            state <= S_SAT;
          end else begin
            tone_idx <= tone_idx + 1'b1;
            state    <= S_ADV;
          end
        end
        S_SAT: begin
          res[chan_idx] <= sat_val;
          sum           <= '0;
          tone_idx      <= '0;
          chan_idx      <= chan_idx + 1'b1;
          state         <= chan_last ? S_DONE : S_ADV;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            chan0_out <= res[0];
            chan1_out <= res[1];
            chan2_out <= res[2];
            chan3_out <= res[3];
            chan4_out <= res[4];
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/mmdds_chk.sv
// Port-level checker for the multitone DDS, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mmdds_chk (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic [mmdds_pkg::MODE_W-1:0]        mode,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [mmdds_pkg::OUT_W-1:0]  chan0_out,
  input wire logic signed [mmdds_pkg::OUT_W-1:0]  chan1_out,
  input wire logic signed [mmdds_pkg::OUT_W-1:0]  chan2_out,
  input wire logic signed [mmdds_pkg::OUT_W-1:0]  chan3_out,
  input wire logic signed [mmdds_pkg::OUT_W-1:0]  chan4_out
);
  import mmdds_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chan0_out) && $stable(chan1_out)
      && $stable(chan2_out) && $stable(chan3_out) && $stable(chan4_out))
    else $error("output transaction dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_restart_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode == MODE_RESTART |=> in_ready)
    else $error("restart transaction left input not ready");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a tick in progress");

endmodule

bind multichannel_multitone_dds mmdds_chk u_mmdds_chk (.*);

`default_nettype wire
